// ===== sv/avpjb_pkg.sv =====
package avpjb_pkg;

   localparam int TIME_BITS = 64;
   localparam int CFG_BITS = 16;
   localparam int NS_BITS = 20;
   localparam int NEED_BITS = CFG_BITS + NS_BITS;
   localparam logic [NS_BITS-1:0] NS_PER_MS = NS_BITS'(1000000);

   localparam int LANES = 2;
   localparam logic LANE_VIDEO = 1'b0;
   localparam logic LANE_AUDIO = 1'b1;

   typedef enum logic [2:0] {
      OP_PUSH_VIDEO = 3'd0,
      OP_PUSH_AUDIO = 3'd1,
      OP_TICK       = 3'd2,
      OP_POP_VIDEO  = 3'd3,
      OP_POP_AUDIO  = 3'd4,
      OP_CLEAR      = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP_READ,
      S_TICK_OFFSET,
      S_TICK_CHECK,
      S_EMIT
   } state_type;

endpackage

// ===== sv/avpjb_req_if.sv =====
interface avpjb_req_if #(
   parameter int HANDLE_BITS = 16
);
   import avpjb_pkg::*;

   logic                   valid;
   logic                   ready;
   op_type                 op;
   logic [TIME_BITS-1:0]   frame_time;
   logic [HANDLE_BITS-1:0] frame_handle;
   logic [TIME_BITS-1:0]   now_time;

   modport source (output valid, op, frame_time, frame_handle, now_time, input ready);
   modport sink (input valid, op, frame_time, frame_handle, now_time, output ready);
endinterface

// ===== sv/avpjb_rsp_if.sv =====
interface avpjb_rsp_if #(
   parameter int HANDLE_BITS = 16,
   parameter int CNT_BITS = 7
);
   import avpjb_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   playing;
   logic                   video_due;
   logic                   audio_due;
   logic [HANDLE_BITS-1:0] video_front_handle;
   logic [HANDLE_BITS-1:0] audio_front_handle;
   logic [CNT_BITS-1:0]    video_count;
   logic [CNT_BITS-1:0]    audio_count;
   status_type             status;

   modport source (
      output valid, playing, video_due, audio_due, video_front_handle,
             audio_front_handle, video_count, audio_count, status,
      input  ready
   );
   modport sink (
      input  valid, playing, video_due, audio_due, video_front_handle,
             audio_front_handle, video_count, audio_count, status,
      output ready
   );
endinterface

// ===== sv/avpjb_ram.sv =====
module avpjb_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 80,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   import avpjb_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/av_playout_jitter_buffer.sv =====
// playout jitter buffer for one audio/video stream
//
// req_chan carries commands (push video/audio, tick, pop video/audio, clear);
// a command is taken when valid and ready are both high. every command gives
// exactly one word on rsp_chan. csr_we/csr_wdata write the start buffer in
// milliseconds; a write also re-arms waiting for the start buffer.
//
// commands are handled one at a time by a small sequencer. a push, clear or
// unused code goes from acceptance through one execute state to the output
// register, a pop adds one read of the frame memory for the new front entry,
// a tick takes three steps of 64-bit compare and offset arithmetic. the next
// command is taken only after the word has been loaded into the output
// register and the sequencer has gone back to idle. a word waiting in the
// output register does not stop the next command; only a second finished
// word is held back until the receiver takes the first.
//
// reset (synchronous) empties both queues, clears the play offset, arms
// waiting and sets the start buffer to zero. frame memory is not cleared.
module av_playout_jitter_buffer #(
   parameter int FIFO_DEPTH = 64,
   parameter int HANDLE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   avpjb_req_if.sink                       req_chan,
   avpjb_rsp_if.source                     rsp_chan,
   input  logic                            csr_we,
   input  logic [avpjb_pkg::CFG_BITS-1:0]  csr_wdata
);
   import avpjb_pkg::*;

   localparam int PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_BITS = CNT_BITS + 1;
   localparam int WORD_BITS = TIME_BITS + HANDLE_BITS;

   state_type               state_ff, state_in;

   logic [PTR_BITS-1:0]     head_ff [LANES];
   logic [PTR_BITS-1:0]     head_in [LANES];
   logic [CNT_BITS-1:0]     count_ff [LANES];
   logic [CNT_BITS-1:0]     count_in [LANES];
   logic [TIME_BITS-1:0]    front_time_ff [LANES];
   logic [TIME_BITS-1:0]    front_time_in [LANES];
   logic [TIME_BITS-1:0]    back_time_ff [LANES];
   logic [TIME_BITS-1:0]    back_time_in [LANES];
   logic [HANDLE_BITS-1:0]  front_handle_ff [LANES];
   logic [HANDLE_BITS-1:0]  front_handle_in [LANES];

   logic                    waiting_ff, waiting_in;
   logic                    offset_valid_ff, offset_valid_in;
   logic [TIME_BITS-1:0]    play_offset_ff, play_offset_in;
   logic [NEED_BITS-1:0]    need_ff, need_in;

   op_type                  cmd_op_ff, cmd_op_in;
   logic                    cmd_lane_ff, cmd_lane_in;
   logic [TIME_BITS-1:0]    cmd_time_ff, cmd_time_in;
   logic [HANDLE_BITS-1:0]  cmd_handle_ff, cmd_handle_in;
   logic [TIME_BITS-1:0]    cmd_now_ff, cmd_now_in;

   logic                    min_ok_ff, min_ok_in;
   logic                    video_first_ff, video_first_in;
   logic                    run_check_ff, run_check_in;

   logic                    res_playing_ff, res_playing_in;
   logic                    res_due_ff [LANES];
   logic                    res_due_in [LANES];
   status_type              res_status_ff, res_status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_playing_ff, rsp_playing_in;
   logic                    rsp_due_ff [LANES];
   logic                    rsp_due_in [LANES];
   logic [HANDLE_BITS-1:0]  rsp_handle_ff [LANES];
   logic [HANDLE_BITS-1:0]  rsp_handle_in [LANES];
   logic [CNT_BITS-1:0]     rsp_count_ff [LANES];
   logic [CNT_BITS-1:0]     rsp_count_in [LANES];
   status_type              rsp_status_ff, rsp_status_in;

   logic [PTR_BITS-1:0]     tail_slot [LANES];
   logic [PTR_BITS-1:0]     next_head [LANES];
   logic                    ram_wr_en [LANES];
   logic                    ram_rd_en [LANES];
   logic [WORD_BITS-1:0]    ram_rd_data [LANES];
   logic [WORD_BITS-1:0]    ram_wr_data;

   logic                    both_nonempty;
   logic                    span_ok [LANES];
   logic                    behind [LANES];
   logic                    due_off [LANES];
   logic                    due_zero [LANES];
   logic                    enough;
   logic [TIME_BITS-1:0]    min_front;

   assign ram_wr_data = {cmd_time_ff, cmd_handle_ff};

   // slot addressing, wraps at any depth
   always_comb begin
      logic [SUM_BITS-1:0] sum;
      for (int l = 0; l < LANES; l++) begin
         sum = SUM_BITS'(head_ff[l]) + SUM_BITS'(count_ff[l]);
         if (sum >= SUM_BITS'(FIFO_DEPTH)) begin
            sum = sum - SUM_BITS'(FIFO_DEPTH);
         end
         tail_slot[l] = sum[PTR_BITS-1:0];
         if (head_ff[l] == PTR_BITS'(FIFO_DEPTH - 1)) begin
            next_head[l] = '0;
         end else begin
            next_head[l] = head_ff[l] + 1'b1;
         end
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      avpjb_ram #(
         .DEPTH (FIFO_DEPTH),
         .WIDTH (WORD_BITS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_wr_en[g]),
         .wr_addr (tail_slot[g]),
         .wr_data (ram_wr_data),
         .rd_en   (ram_rd_en[g]),
         .rd_addr (next_head[g]),
         .rd_data (ram_rd_data[g])
      );
   end

   // tick arithmetic, one group per sequencer step
   always_comb begin
      both_nonempty = (count_ff[LANE_VIDEO] != '0) && (count_ff[LANE_AUDIO] != '0);
      min_front = video_first_ff ? front_time_ff[LANE_VIDEO] : front_time_ff[LANE_AUDIO];
      for (int l = 0; l < LANES; l++) begin
         span_ok[l]  = (back_time_ff[l] - front_time_ff[l]) >= TIME_BITS'(need_ff);
         behind[l]   = (back_time_ff[l] + play_offset_ff) < cmd_now_ff;
         due_off[l]  = (count_ff[l] != '0) && ((front_time_ff[l] + play_offset_ff) <= cmd_now_ff);
         due_zero[l] = (count_ff[l] != '0) && (front_time_ff[l] <= cmd_now_ff);
      end
      enough = both_nonempty && !behind[LANE_VIDEO] && !behind[LANE_AUDIO];
   end

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      waiting_in      = waiting_ff;
      offset_valid_in = offset_valid_ff;
      play_offset_in  = play_offset_ff;
      need_in         = need_ff;
      cmd_op_in       = cmd_op_ff;
      cmd_lane_in     = cmd_lane_ff;
      cmd_time_in     = cmd_time_ff;
      cmd_handle_in   = cmd_handle_ff;
      cmd_now_in      = cmd_now_ff;
      min_ok_in       = min_ok_ff;
      video_first_in  = video_first_ff;
      run_check_in    = run_check_ff;
      res_playing_in  = res_playing_ff;
      res_status_in   = res_status_ff;
      rsp_playing_in  = rsp_playing_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      for (int l = 0; l < LANES; l++) begin
         head_in[l]         = head_ff[l];
         count_in[l]        = count_ff[l];
         front_time_in[l]   = front_time_ff[l];
         back_time_in[l]    = back_time_ff[l];
         front_handle_in[l] = front_handle_ff[l];
         res_due_in[l]      = res_due_ff[l];
         rsp_due_in[l]      = rsp_due_ff[l];
         rsp_handle_in[l]   = rsp_handle_ff[l];
         rsp_count_in[l]    = rsp_count_ff[l];
         ram_wr_en[l]       = 1'b0;
         ram_rd_en[l]       = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_op_in     = req_chan.op;
               cmd_lane_in   = (req_chan.op == OP_PUSH_AUDIO) || (req_chan.op == OP_POP_AUDIO);
               cmd_time_in   = req_chan.frame_time;
               cmd_handle_in = req_chan.frame_handle;
               cmd_now_in    = req_chan.now_time;
               state_in      = S_EXEC;
            end
         end

         S_EXEC: begin
            res_playing_in = 1'b0;
            res_due_in[LANE_VIDEO] = 1'b0;
            res_due_in[LANE_AUDIO] = 1'b0;
            res_status_in  = ST_OK;
            state_in       = S_EMIT;
            case (cmd_op_ff)
               OP_PUSH_VIDEO, OP_PUSH_AUDIO: begin
                  if (count_ff[cmd_lane_ff] == CNT_BITS'(FIFO_DEPTH)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     ram_wr_en[cmd_lane_ff]    = 1'b1;
                     back_time_in[cmd_lane_ff] = cmd_time_ff;
                     if (count_ff[cmd_lane_ff] == '0) begin
                        front_time_in[cmd_lane_ff]   = cmd_time_ff;
                        front_handle_in[cmd_lane_ff] = cmd_handle_ff;
                     end
                     count_in[cmd_lane_ff] = count_ff[cmd_lane_ff] + 1'b1;
                  end
               end
               OP_POP_VIDEO, OP_POP_AUDIO: begin
                  if (count_ff[cmd_lane_ff] == '0) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     // fetch the entry that becomes the front
                     ram_rd_en[cmd_lane_ff] = 1'b1;
                     head_in[cmd_lane_ff]   = next_head[cmd_lane_ff];
                     count_in[cmd_lane_ff]  = count_ff[cmd_lane_ff] - 1'b1;
                     state_in = S_POP_READ;
                  end
               end
               OP_TICK: begin
                  min_ok_in      = both_nonempty && span_ok[LANE_VIDEO] && span_ok[LANE_AUDIO];
                  video_first_in = front_time_ff[LANE_VIDEO] < front_time_ff[LANE_AUDIO];
                  state_in       = S_TICK_OFFSET;
               end
               OP_CLEAR: begin
                  for (int l = 0; l < LANES; l++) begin
                     head_in[l]  = '0;
                     count_in[l] = '0;
                  end
                  offset_valid_in = 1'b0;
                  play_offset_in  = '0;
                  waiting_in      = 1'b1;
               end
               default: begin
               end
            endcase
         end

         S_POP_READ: begin
            front_time_in[cmd_lane_ff]   = ram_rd_data[cmd_lane_ff][WORD_BITS-1:HANDLE_BITS];
            front_handle_in[cmd_lane_ff] = ram_rd_data[cmd_lane_ff][HANDLE_BITS-1:0];
            state_in = S_EMIT;
         end

         S_TICK_OFFSET: begin
            if (waiting_ff && !min_ok_ff) begin
               run_check_in = 1'b0;
            end else begin
               run_check_in = 1'b1;
               waiting_in   = 1'b0;
               if (!offset_valid_ff && both_nonempty) begin
                  play_offset_in  = cmd_now_ff - min_front;
                  offset_valid_in = 1'b1;
               end
            end
            state_in = S_TICK_CHECK;
         end

         S_TICK_CHECK: begin
            if (run_check_ff && !enough) begin
               // underrun: drop the offset and wait for the start buffer again
               offset_valid_in = 1'b0;
               play_offset_in  = '0;
               waiting_in      = 1'b1;
               res_due_in[LANE_VIDEO] = due_zero[LANE_VIDEO];
               res_due_in[LANE_AUDIO] = due_zero[LANE_AUDIO];
            end else begin
               res_due_in[LANE_VIDEO] = due_off[LANE_VIDEO];
               res_due_in[LANE_AUDIO] = due_off[LANE_AUDIO];
            end
            res_playing_in = run_check_ff && enough;
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_playing_in = res_playing_ff;
               rsp_status_in  = res_status_ff;
               for (int l = 0; l < LANES; l++) begin
                  rsp_due_in[l]    = res_due_ff[l];
                  rsp_count_in[l]  = count_ff[l];
                  rsp_handle_in[l] = (count_ff[l] != '0) ? front_handle_ff[l] : '0;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         need_in    = NEED_BITS'(csr_wdata) * NEED_BITS'(NS_PER_MS);
         waiting_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         waiting_ff      <= 1'b1;
         offset_valid_ff <= 1'b0;
         play_offset_ff  <= '0;
         need_ff         <= '0;
         for (int l = 0; l < LANES; l++) begin
            head_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         waiting_ff      <= waiting_in;
         offset_valid_ff <= offset_valid_in;
         play_offset_ff  <= play_offset_in;
         need_ff         <= need_in;
         for (int l = 0; l < LANES; l++) begin
            head_ff[l]  <= head_in[l];
            count_ff[l] <= count_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_op_ff      <= cmd_op_in;
      cmd_lane_ff    <= cmd_lane_in;
      cmd_time_ff    <= cmd_time_in;
      cmd_handle_ff  <= cmd_handle_in;
      cmd_now_ff     <= cmd_now_in;
      min_ok_ff      <= min_ok_in;
      video_first_ff <= video_first_in;
      run_check_ff   <= run_check_in;
      res_playing_ff <= res_playing_in;
      res_status_ff  <= res_status_in;
      rsp_playing_ff <= rsp_playing_in;
      rsp_status_ff  <= rsp_status_in;
      for (int l = 0; l < LANES; l++) begin
         front_time_ff[l]   <= front_time_in[l];
         back_time_ff[l]    <= back_time_in[l];
         front_handle_ff[l] <= front_handle_in[l];
         res_due_ff[l]      <= res_due_in[l];
         rsp_due_ff[l]      <= rsp_due_in[l];
         rsp_handle_ff[l]   <= rsp_handle_in[l];
         rsp_count_ff[l]    <= rsp_count_in[l];
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.playing            = rsp_playing_ff;
   assign rsp_chan.video_due          = rsp_due_ff[LANE_VIDEO];
   assign rsp_chan.audio_due          = rsp_due_ff[LANE_AUDIO];
   assign rsp_chan.video_front_handle = rsp_handle_ff[LANE_VIDEO];
   assign rsp_chan.audio_front_handle = rsp_handle_ff[LANE_AUDIO];
   assign rsp_chan.video_count        = rsp_count_ff[LANE_VIDEO];
   assign rsp_chan.audio_count        = rsp_count_ff[LANE_AUDIO];
   assign rsp_chan.status             = rsp_status_ff;
endmodule
